// ===== hdl/three_wire_rtc_serial_master_top_assert.svh =====
// Assertion macros used by the serial master checker
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_TOP_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RTC3W_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RTC3W_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rtc3w_pkg.sv =====
// Types, constants and helpers for the three-wire serial master
package rtc3w_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BYTE_W        = 8;
   localparam int BIT_IDX_W     = $clog2(2 * BITS_PER_BYTE);
   localparam int HALF_W        = 16;
   localparam int ACTION_W      = 2;

   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [HALF_W-1:0] HALF_RESET = 16'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   address;
      logic [BYTE_W-1:0]   write_data;
      logic                io_in;
   } item_type;

   typedef struct packed {
      logic              chip_enable;
      logic              serial_clock;
      logic              io_out;
      logic              io_drive;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_raw;
      logic [BYTE_W-1:0] read_decoded;
   } result_type;

   // high nibble * 10 + low nibble
   function automatic logic [BYTE_W-1:0] bcd_decode(input logic [BYTE_W-1:0] v);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = v[7:4];
      lo = v[3:0];
      return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
   endfunction

endpackage

// ===== hdl/three_wire_rtc_serial_master_top.sv =====
// A req transfer reaches its rsp result through the input reg and the result reg.
// Throughput: one tick item per cycle while rsp_tready does not stall; bit timing
// counted in items, half period from the csr register.
// Reset (synchronous, active high) clears both stage valids and all transfer
// state; csr register returns to 2.
module three_wire_rtc_serial_master_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // address, write_data, io_in, pad
   input  logic [rtc3w_pkg::ACTION_W-1:0]   req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // chip_enable, serial_clock, io_out, io_drive, busy_res, done_res,
   // read_raw, read_decoded, pad
   output logic [23:0]                      rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [rtc3w_pkg::HALF_W-1:0]     csr_wr_data
);

   logic                             in_valid_ff, in_valid_in;
   rtc3w_pkg::item_type              in_item_ff;
   logic                             out_valid_ff, out_valid_in;
   rtc3w_pkg::result_type            out_res_ff;
   logic [rtc3w_pkg::HALF_W-1:0]     half_ff;
   rtc3w_pkg::result_type            step_res;
   rtc3w_pkg::item_type              req_item;
   logic                             adv;
   logic                             req_xfer;

   assign req_item.action     = req_tuser;
   assign req_item.address    = req_tdata[7:0];
   assign req_item.write_data = req_tdata[15:8];
   assign req_item.io_in      = req_tdata[16];

   assign adv          = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | adv;
   assign req_xfer     = req_tvalid & req_tready;
   assign in_valid_in  = req_xfer | (in_valid_ff & ~adv);
   assign out_valid_in = adv | (out_valid_ff & ~rsp_tready);

   rtc3w_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (adv),
      .item       (in_item_ff),
      .half_ticks (half_ff),
      .result     (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         half_ff      <= rtc3w_pkg::HALF_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_item;
      end
      if (adv) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_res_ff.read_decoded,
                        out_res_ff.read_raw,
                        out_res_ff.done_res,
                        out_res_ff.busy_res,
                        out_res_ff.io_drive,
                        out_res_ff.io_out,
                        out_res_ff.serial_clock,
                        out_res_ff.chip_enable};

endmodule

// ===== hdl/rtc3w_core.sv =====
// Bit sequencer: transfer state and per-tick line levels
module rtc3w_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  rtc3w_pkg::item_type             item,
   input  logic [rtc3w_pkg::HALF_W-1:0]    half_ticks,
   output rtc3w_pkg::result_type           result
);

   typedef enum logic [1:0] {PH_IDLE, PH_LOW, PH_HIGH} phase_type;

   localparam logic [rtc3w_pkg::BIT_IDX_W-1:0] BYTE_IDX =
      rtc3w_pkg::BIT_IDX_W'(rtc3w_pkg::BITS_PER_BYTE);
   localparam logic [rtc3w_pkg::BIT_IDX_W-1:0] LAST_IDX =
      rtc3w_pkg::BIT_IDX_W'(2 * rtc3w_pkg::BITS_PER_BYTE - 1);

   phase_type                            phase_ff, phase_in;
   logic [rtc3w_pkg::BIT_IDX_W-1:0]      bit_idx_ff, bit_idx_in;
   logic [rtc3w_pkg::BYTE_W-1:0]         addr_sh_ff, addr_sh_in;
   logic [rtc3w_pkg::BYTE_W-1:0]         data_sh_ff, data_sh_in;
   logic [rtc3w_pkg::BYTE_W-1:0]         read_sh_ff, read_sh_in;
   logic [rtc3w_pkg::HALF_W-1:0]         wait_ff, wait_in;
   logic                                 is_read_ff, is_read_in;
   logic                                 done;
   logic                                 busy;
   logic                                 addr_phase;
   logic                                 drive;

   always_comb begin
      phase_in   = phase_ff;
      bit_idx_in = bit_idx_ff;
      addr_sh_in = addr_sh_ff;
      data_sh_in = data_sh_ff;
      read_sh_in = read_sh_ff;
      wait_in    = wait_ff;
      is_read_in = is_read_ff;
      done       = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (item.action == rtc3w_pkg::ACT_WRITE || item.action == rtc3w_pkg::ACT_READ) begin
               addr_sh_in = item.address;
               data_sh_in = item.write_data;
               is_read_in = (item.action == rtc3w_pkg::ACT_READ);
               bit_idx_in = '0;
               wait_in    = '0;
               phase_in   = PH_LOW;
            end
         end
         PH_LOW: begin
            if (is_read_ff && bit_idx_ff >= BYTE_IDX) begin
               read_sh_in = {item.io_in, read_sh_ff[rtc3w_pkg::BYTE_W-1:1]};
            end
            wait_in  = half_ticks;
            phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            if (wait_ff > rtc3w_pkg::HALF_W'(1)) begin
               wait_in = wait_ff - rtc3w_pkg::HALF_W'(1);
            end else begin
               wait_in = '0;
               if (bit_idx_ff < BYTE_IDX) begin
                  addr_sh_in = addr_sh_ff >> 1;
               end else if (!is_read_ff) begin
                  data_sh_in = data_sh_ff >> 1;
               end
               if (bit_idx_ff == LAST_IDX) begin
                  bit_idx_in = '0;
                  phase_in   = PH_IDLE;
                  done       = 1'b1;
               end else begin
                  bit_idx_in = bit_idx_ff + rtc3w_pkg::BIT_IDX_W'(1);
                  phase_in   = PH_LOW;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = (phase_in != PH_IDLE);
      addr_phase = (bit_idx_in < BYTE_IDX);
      drive      = busy && (addr_phase || !is_read_in);
      result.chip_enable  = busy;
      result.serial_clock = (phase_in == PH_HIGH);
      result.io_out       = drive && (addr_phase ? addr_sh_in[0] : data_sh_in[0]);
      result.io_drive     = drive;
      result.busy_res     = busy;
      result.done_res     = done;
      result.read_raw     = read_sh_in;
      result.read_decoded = rtc3w_pkg::bcd_decode(read_sh_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_idx_ff <= '0;
         addr_sh_ff <= '0;
         data_sh_ff <= '0;
         read_sh_ff <= '0;
         wait_ff    <= '0;
         is_read_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         addr_sh_ff <= addr_sh_in;
         data_sh_ff <= data_sh_in;
         read_sh_ff <= read_sh_in;
         wait_ff    <= wait_in;
         is_read_ff <= is_read_in;
      end
   end

endmodule

// ===== hdl/rtc3w_checker.sv =====
// Port-level checker for the serial master, bound to the top level
`include "three_wire_rtc_serial_master_top_assert.svh"

module rtc3w_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic [23:0] rsp_tdata
);

   `RTC3W_ASSERT_NOW(a_io_only_when_driven, clock, reset, rsp_tvalid && rsp_tdata[2], rsp_tdata[3], "io_out high while line released")
   `RTC3W_ASSERT_NOW(a_ce_matches_busy, clock, reset, rsp_tvalid, rsp_tdata[0] == rsp_tdata[4], "chip enable differs from busy")
   `RTC3W_ASSERT_NOW(a_done_ends_busy, clock, reset, rsp_tvalid && rsp_tdata[5], !rsp_tdata[4] && !rsp_tdata[1], "done while still busy")
   `RTC3W_ASSERT_NOW(a_no_result_after_reset, clock, reset, $past(reset), !rsp_tvalid, "result valid right after reset")

endmodule

bind three_wire_rtc_serial_master_top rtc3w_checker u_rtc3w_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata)
);
